>>> hw/rtl/acps_pkg.sv
package acps_pkg;

  localparam int MAX_FRAME_DEF     = 1024;
  localparam int SAMPLE_BITS_DEF   = 12;
  localparam int MAX_CROSSINGS_DEF = 100;
  localparam int SKIP_AFTER        = 3;
  localparam int FIFO_DEPTH        = 4;
  localparam int CFG_DATA_W        = 16;
  localparam int CFG_IDX_W         = 2;

  typedef enum logic [1:0] {
    REG_ZERO_LEVEL = 2'd0,
    REG_MARGIN     = 2'd1,
    REG_FRAME_LEN  = 2'd2,
    REG_GAIN       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] frame_min;
    logic [11:0] frame_max;
    logic [11:0] frame_avg;
    logic [6:0]  crossing_count;
    logic [11:0] peak_high;
    logic [11:0] peak_low;
    logic [11:0] trough_high;
    logic [11:0] trough_low;
    logic [9:0]  first_peak_pos;
    logic signed [15:0] cal_min;
    logic signed [15:0] cal_max;
    logic signed [15:0] cal_avg;
  } result_t;

endpackage

>>> hw/rtl/acps_if.sv
interface acps_sample_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface acps_result_if;
  logic              valid;
  logic              ready;
  acps_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/acps_front.sv
module acps_front #(
  parameter int SAMPLE_BITS = acps_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH       = acps_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_sample,
  output logic        q_valid,
  input  logic        q_take,
  output logic [11:0] q_sample
);
  localparam int AW = $clog2(DEPTH);

  logic [11:0] buffer [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;
  logic          push;
  logic          pop;
  logic [11:0]   masked;

  assign masked   = in_sample & 12'((1 << SAMPLE_BITS) - 1);
  assign in_ready = fill != (AW+1)'(DEPTH);
  assign push     = in_valid && in_ready;
  assign q_valid  = fill != '0;
  assign pop      = q_valid && q_take;
  assign q_sample = buffer[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buffer[wr_ptr] <= masked;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (AW+1)'(DEPTH)) else $error("queue overfilled");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + 1'b1) else $error("fill count slip");
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    fill == '0 |-> !pop) else $error("pop from empty queue");
endmodule

>>> hw/rtl/acps_back.sv
module acps_back #(
  parameter int MAX_FRAME     = acps_pkg::MAX_FRAME_DEF,
  parameter int MAX_CROSSINGS = acps_pkg::MAX_CROSSINGS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_take,
  input  logic [11:0]       q_sample,
  input  logic [11:0]       zero_level,
  input  logic [11:0]       crossing_margin,
  input  logic [10:0]       frame_len,
  input  logic signed [15:0] gain,
  output logic              res_valid,
  input  logic              res_ready,
  output acps_pkg::result_t res_data
);
  typedef enum logic [2:0] {
    S_RUN, S_DIV, S_CAL0, S_CAL1, S_CAL2, S_OUT
  } state_t;

  state_t state;
  logic [10:0] sample_index;
  logic [11:0] look0, look1;
  logic [21:0] running_sum;
  logic [11:0] running_min, running_max;
  logic [6:0]  crossings_seen;
  logic [1:0]  skip_left;
  logic [11:0] per_min, per_max;
  logic [9:0]  per_pos;
  logic [11:0] sum_ph, sum_pl, sum_th, sum_tl;
  logic [9:0]  first_pos;
  logic [21:0] rem;
  logic [11:0] quot;
  logic [10:0] len_hold;
  logic [4:0]  div_cnt;
  logic [11:0] cal_in;
  acps_pkg::result_t res;

  logic [10:0] len;
  logic [15:0] thr;
  logic        take;
  logic        crossing;
  logic [10:0] rem_hi_diff;
  logic signed [12:0] diff;
  logic signed [28:0] prod;
  logic signed [28:0] shifted;
  logic signed [15:0] sat;

  always_comb begin
    if (frame_len < 11'd3) begin
      len = 11'd3;
    end else if (32'(frame_len) > MAX_FRAME) begin
      len = 11'(MAX_FRAME);
    end else begin
      len = frame_len;
    end
  end

  assign thr = 16'(zero_level) - 16'(crossing_margin);
  assign q_take = state == S_RUN;
  assign take = q_valid && q_take;
  assign crossing = sample_index >= 11'd2 && 32'(crossings_seen) < MAX_CROSSINGS
                 && skip_left == 2'd0 && 16'(look1) > thr && 16'(look0) <= thr
                 && 16'(q_sample) < thr;
  assign rem_hi_diff = rem[21:11] - len_hold;
  assign diff = $signed({1'b0, cal_in}) - $signed({1'b0, zero_level});
  assign prod = diff * gain;
  assign shifted = (prod + ((prod < 0) ? 29'sd255 : 29'sd0)) >>> 8;
  assign sat = (shifted > 29'sd32767) ? 16'sh7fff :
               (shifted < -29'sd32768) ? 16'sh8000 : shifted[15:0];
  assign res_valid = state == S_OUT;
  assign res_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      sample_index <= '0;
      look0 <= '0;
      look1 <= '0;
      running_sum <= '0;
      running_min <= 12'hfff;
      running_max <= '0;
      crossings_seen <= '0;
      skip_left <= '0;
      per_min <= 12'hfff;
      per_max <= '0;
      per_pos <= '0;
      sum_ph <= '0;
      sum_pl <= 12'hfff;
      sum_th <= '0;
      sum_tl <= 12'hfff;
      first_pos <= '0;
      div_cnt <= '0;
    end else begin
      case (state)
        S_RUN: begin
          if (take) begin
            running_sum <= running_sum + 22'(q_sample);
            if (q_sample < running_min) running_min <= q_sample;
            if (q_sample > running_max) running_max <= q_sample;
            if (sample_index >= 11'd2 && 32'(crossings_seen) < MAX_CROSSINGS
                && skip_left != 2'd0) begin
              skip_left <= skip_left - 2'd1;
            end
            if (crossing) begin
              if (crossings_seen >= 7'd1) begin
                if (per_max > sum_ph) sum_ph <= per_max;
                if (per_max < sum_pl) sum_pl <= per_max;
                if (per_min > sum_th) sum_th <= per_min;
                if (per_min < sum_tl) sum_tl <= per_min;
                if (crossings_seen == 7'd1) first_pos <= per_pos;
              end
              crossings_seen <= crossings_seen + 7'd1;
              skip_left <= 2'(acps_pkg::SKIP_AFTER);
            end
            if (sample_index >= 11'd1 && 32'(crossings_seen) + (crossing ? 1 : 0) >= 1
                && 32'(crossings_seen) + (crossing ? 1 : 0) < MAX_CROSSINGS) begin
              if (crossing) begin
                per_max <= look0;
                per_min <= look0;
                per_pos <= 10'(sample_index - 11'd1);
              end else begin
                if (look0 > per_max) begin
                  per_max <= look0;
                  per_pos <= 10'(sample_index - 11'd1);
                end
                if (look0 < per_min) per_min <= look0;
              end
            end else if (crossing) begin
              per_min <= 12'hfff;
              per_max <= '0;
              per_pos <= 10'(sample_index - 11'd1);
            end
            look1 <= look0;
            look0 <= q_sample;
            if (sample_index + 11'd1 < len) begin
              sample_index <= sample_index + 11'd1;
            end else begin
              rem <= running_sum + 22'(q_sample);
              len_hold <= len;
              quot <= '0;
              div_cnt <= '0;
              res.frame_min <= (q_sample < running_min) ? q_sample : running_min;
              res.frame_max <= (q_sample > running_max) ? q_sample : running_max;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit a cycle, 12 bits total.
          if (rem[21:11] >= len_hold) begin
            rem <= {rem_hi_diff[9:0], rem[10:0], 1'b0};
            quot <= {quot[10:0], 1'b1};
          end else begin
            rem <= {rem[20:0], 1'b0};
            quot <= {quot[10:0], 1'b0};
          end
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd11) begin
            state <= S_CAL0;
          end
        end
        S_CAL0: begin
          res.frame_avg <= quot;
          res.crossing_count <= crossings_seen;
          if (crossings_seen >= 7'd2) begin
            res.peak_high <= sum_ph;
            res.peak_low <= sum_pl;
            res.trough_high <= sum_th;
            res.trough_low <= sum_tl;
            res.first_peak_pos <= first_pos;
            cal_in <= sum_pl;
          end else begin
            res.peak_high <= zero_level;
            res.peak_low <= zero_level;
            res.trough_high <= zero_level;
            res.trough_low <= zero_level;
            res.first_peak_pos <= '0;
            cal_in <= zero_level;
          end
          state <= S_CAL1;
        end
        S_CAL1: begin
          res.cal_min <= sat;
          cal_in <= res.peak_high;
          state <= S_CAL2;
        end
        S_CAL2: begin
          if (cal_in == res.peak_high && div_cnt == 5'd12) begin
            res.cal_max <= sat;
            cal_in <= res.frame_avg;
            div_cnt <= 5'd13;
          end else begin
            res.cal_avg <= sat;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            state <= S_RUN;
            sample_index <= '0;
            running_sum <= '0;
            running_min <= 12'hfff;
            running_max <= '0;
            crossings_seen <= '0;
            skip_left <= '0;
            per_min <= 12'hfff;
            per_max <= '0;
            per_pos <= '0;
            sum_ph <= '0;
            sum_pl <= 12'hfff;
            sum_th <= '0;
            sum_tl <= 12'hfff;
            first_pos <= '0;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

  a_cap: assert property (@(posedge clk) disable iff (rst)
    32'(crossings_seen) <= MAX_CROSSINGS) else $error("crossing count over cap");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    state != S_RUN |-> !take) else $error("sample taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid) else $error("result dropped");
endmodule

>>> hw/rtl/ac_current_period_stats_core.sv
// After the edge that takes the last sample of its frame, the back end runs the bit-serial
// average divider (S_DIV), selects the result fields (S_CAL0), forms the three calibration
// products (S_CAL1, S_CAL2) and then holds the result valid in S_OUT until it is taken.
// Throughput: one sample per cycle within a frame. From the end of a frame until its result
// is taken the back end takes no samples; the four-entry sample queue takes them until full.
// Reset (rst, synchronous) restores register defaults and clears the frame accumulators.
module ac_current_period_stats_core #(
  parameter int MAX_FRAME     = acps_pkg::MAX_FRAME_DEF,
  parameter int SAMPLE_BITS   = acps_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_CROSSINGS = acps_pkg::MAX_CROSSINGS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [acps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acps_pkg::CFG_DATA_W-1:0] cfg_data,
  acps_sample_if.sink   samples,
  acps_result_if.source results
);
  logic [11:0] zero_level;
  logic [11:0] crossing_margin;
  logic [10:0] frame_len;
  logic signed [15:0] gain;
  logic q_valid, q_take;
  logic [11:0] q_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_level <= 12'd2048;
      crossing_margin <= '0;
      frame_len <= 11'd1024;
      gain <= 16'sd256;
    end else if (cfg_we) begin
      case (acps_pkg::reg_idx_t'(cfg_index))
        acps_pkg::REG_ZERO_LEVEL: zero_level <= cfg_data[11:0];
        acps_pkg::REG_MARGIN:     crossing_margin <= cfg_data[11:0];
        acps_pkg::REG_FRAME_LEN:  frame_len <= cfg_data[10:0];
        acps_pkg::REG_GAIN:       gain <= cfg_data;
        default: ;
      endcase
    end
  end

  acps_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst,
    .in_valid(samples.valid), .in_ready(samples.ready), .in_sample(samples.sample),
    .q_valid, .q_take, .q_sample
  );

  acps_back #(.MAX_FRAME(MAX_FRAME), .MAX_CROSSINGS(MAX_CROSSINGS)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_sample,
    .zero_level, .crossing_margin, .frame_len, .gain,
    .res_valid(results.valid), .res_ready(results.ready), .res_data(results.data)
  );
endmodule

>>> dv/ac_current_period_stats_core_test.sv
`timescale 1ns / 1ps

module ac_current_period_stats_core_test;

  localparam int SMAX = 4095;
  localparam int IDLE_AFTER_LAST = 60;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [acps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [acps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  acps_sample_if samples_ch ();
  acps_result_if results_ch ();

  ac_current_period_stats_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .samples(samples_ch.sink), .results(results_ch.source)
  );

  always #5 clk = ~clk;

  // Predictor state; the configuration copies are mirrored at block widths.
  logic [11:0] zero_code, margin;
  logic [10:0] flen;
  logic signed [15:0] gain_q88;
  int unsigned idx, sum, rmin, rmax, ncross, skip, pmin, pmax, ppos, fpos;
  int unsigned lb0, lb1, pk_hi, pk_lo, tr_hi, tr_lo;

  acps_pkg::result_t expected_frames[$];
  logic [11:0] sample_queue[$];
  int errors = 0;
  int frames_seen = 0;
  int samples_sent = 0;
  bit tail_phase = 0;

  task automatic clear_frame();
    idx = 0; sum = 0; rmin = SMAX; rmax = 0; ncross = 0; skip = 0;
    pmin = SMAX; pmax = 0; ppos = 0; fpos = 0;
    pk_hi = 0; pk_lo = SMAX; tr_hi = 0; tr_lo = SMAX;
  endtask

  function automatic logic [15:0] scale(int unsigned v);
    longint d, r;
    d = longint'(v) - longint'(zero_code);
    r = (d * longint'(gain_q88)) / 256;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic predict_sample(logic [11:0] s);
    int unsigned len, thr, avg, z;
    bit enough;
    acps_pkg::result_t r;
    len = flen;
    thr = (int'(zero_code) - int'(margin)) & 16'hFFFF;
    if (len < 3) len = 3;
    if (len > acps_pkg::MAX_FRAME_DEF) len = acps_pkg::MAX_FRAME_DEF;
    sum += s;
    if (s < rmin) rmin = s;
    if (s > rmax) rmax = s;
    if (idx >= 2 && ncross < acps_pkg::MAX_CROSSINGS_DEF) begin
      if (skip > 0) begin
        skip--;
      end else if (lb1 > thr && lb0 <= thr && s < thr) begin
        if (ncross >= 1) begin
          if (pmax > pk_hi) pk_hi = pmax;
          if (pmax < pk_lo) pk_lo = pmax;
          if (pmin > tr_hi) tr_hi = pmin;
          if (pmin < tr_lo) tr_lo = pmin;
          if (ncross == 1) fpos = ppos;
        end
        ncross++;
        skip = acps_pkg::SKIP_AFTER;
        pmin = SMAX; pmax = 0; ppos = idx - 1;
      end
    end
    if (idx >= 1 && ncross >= 1 && ncross < acps_pkg::MAX_CROSSINGS_DEF) begin
      if (lb0 > pmax) begin
        pmax = lb0; ppos = idx - 1;
      end
      if (lb0 < pmin) pmin = lb0;
    end
    lb1 = lb0;
    lb0 = s;
    if (idx + 1 < len) begin
      idx++;
      return;
    end
    avg = sum / len;
    enough = ncross >= 2;
    z = zero_code;
    r.frame_min = 12'(rmin);
    r.frame_max = 12'(rmax);
    r.frame_avg = 12'(avg);
    r.crossing_count = 7'(ncross);
    r.peak_high = 12'(enough ? pk_hi : z);
    r.peak_low = 12'(enough ? pk_lo : z);
    r.trough_high = 12'(enough ? tr_hi : z);
    r.trough_low = 12'(enough ? tr_lo : z);
    r.first_peak_pos = 10'(enough ? fpos : 0);
    r.cal_min = scale(enough ? pk_lo : z);
    r.cal_max = scale(enough ? pk_hi : z);
    r.cal_avg = scale(avg);
    expected_frames.push_back(r);
    clear_frame();
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in frame %0d: %s got %0d expected %0d", frames_seen, what, got, want);
    errors++;
  endtask

  // Driver.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      samples_ch.valid <= 1'b0;
      samples_ch.sample <= '0;
    end else begin
      if (samples_ch.valid && samples_ch.ready) begin
        predict_sample(samples_ch.sample);
        samples_sent++;
      end
      if (!samples_ch.valid || samples_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          samples_ch.valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          samples_ch.valid <= 1'b1;
          samples_ch.sample <= sample_queue.pop_front();
          if (!tail_phase && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 10);
        end else begin
          samples_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  int stall = 0;
  always @(posedge clk) begin
    acps_pkg::result_t got, want;
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      if (results_ch.valid && results_ch.ready) begin
        got = results_ch.data;
        if (expected_frames.size() == 0) begin
          $display("result with no frame pending");
          errors++;
        end else begin
          want = expected_frames.pop_front();
          if (got.frame_min !== want.frame_min)
            report_mismatch("frame_min", got.frame_min, want.frame_min);
          if (got.frame_max !== want.frame_max)
            report_mismatch("frame_max", got.frame_max, want.frame_max);
          if (got.frame_avg !== want.frame_avg)
            report_mismatch("frame_avg", got.frame_avg, want.frame_avg);
          if (got.crossing_count !== want.crossing_count)
            report_mismatch("crossing_count", got.crossing_count, want.crossing_count);
          if (got.peak_high !== want.peak_high)
            report_mismatch("peak_high", got.peak_high, want.peak_high);
          if (got.peak_low !== want.peak_low)
            report_mismatch("peak_low", got.peak_low, want.peak_low);
          if (got.trough_high !== want.trough_high)
            report_mismatch("trough_high", got.trough_high, want.trough_high);
          if (got.trough_low !== want.trough_low)
            report_mismatch("trough_low", got.trough_low, want.trough_low);
          if (got.first_peak_pos !== want.first_peak_pos)
            report_mismatch("first_peak_pos", got.first_peak_pos, want.first_peak_pos);
          if (got.cal_min !== want.cal_min)
            report_mismatch("cal_min", got.cal_min, want.cal_min);
          if (got.cal_max !== want.cal_max)
            report_mismatch("cal_max", got.cal_max, want.cal_max);
          if (got.cal_avg !== want.cal_avg)
            report_mismatch("cal_avg", got.cal_avg, want.cal_avg);
        end
        frames_seen++;
      end
      if (stall > 0) begin
        stall <= stall - 1;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= 1'b1;
        if (!tail_phase && $urandom_range(0, 5) == 0) stall <= $urandom_range(1, 10);
      end
    end
  end

  // Watchdog.
  int quiet = 0;
  always @(posedge clk) begin
    if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > STALL_LIMIT) begin
      $display("ac_current_period_stats_core_test: errors");
      $finish;
    end
  end

  task automatic write_reg(acps_pkg::reg_idx_t r, int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= 16'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      acps_pkg::REG_ZERO_LEVEL: zero_code = v[11:0];
      acps_pkg::REG_MARGIN: margin = v[11:0];
      acps_pkg::REG_FRAME_LEN: flen = v[10:0];
      default: gain_q88 = v[15:0];
    endcase
  endtask

  task automatic drain();
    while (sample_queue.size() > 0 || samples_ch.valid || expected_frames.size() > 0)
      @(posedge clk);
    repeat (IDLE_AFTER_LAST) @(posedge clk);
  endtask

  // One frame of a square-ish wave with random levels and period.
  task automatic queue_wave_frame(int len, int per);
    int lo, hi, thr;
    thr = (int'(zero_code) - int'(margin)) & 16'hFFFF;
    for (int i = 0; i < len; i++) begin
      lo = (thr > 0) ? $urandom_range(0, (thr > 4095 ? 4095 : thr - 1)) : 0;
      hi = (thr < 4095) ? $urandom_range(thr + 1, 4095) : 4095;
      if ($urandom_range(0, 15) == 0)
        sample_queue.push_back(12'($urandom_range(0, 4095)));
      else
        sample_queue.push_back(12'(((i % per) < per / 2) ? hi : lo));
    end
  endtask

  initial begin
    int plen, per;
    zero_code = 2048; margin = 0; flen = 1024; gain_q88 = 256;
    lb0 = 0; lb1 = 0;
    clear_frame();
    samples_ch.valid = 1'b0;
    samples_ch.sample = '0;
    results_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: short frames with extremes, flat frame, one crossing pattern, wrapped-threshold wave.
    write_reg(acps_pkg::REG_FRAME_LEN, 3);
    write_reg(acps_pkg::REG_GAIN, 16'h7FFF);
    sample_queue = '{12'd0, 12'd4095, 12'd4095, 12'hAAA, 12'h555, 12'd0};
    drain();
    write_reg(acps_pkg::REG_FRAME_LEN, 0);
    write_reg(acps_pkg::REG_GAIN, 16'h8000);
    sample_queue = '{12'd4095, 12'd4095, 12'd4095};
    drain();
    write_reg(acps_pkg::REG_FRAME_LEN, 12);
    write_reg(acps_pkg::REG_ZERO_LEVEL, 2000);
    write_reg(acps_pkg::REG_MARGIN, 100);
    sample_queue = '{12'd3000, 12'd1900, 12'd1000, 12'd3000, 12'd3000, 12'd3000,
                     12'd3000, 12'd1900, 12'd100, 12'd2500, 12'd1900, 12'd0};
    drain();
    write_reg(acps_pkg::REG_MARGIN, 4095);
    queue_wave_frame(12, 6);
    drain();

    // Random phases.
    for (int ph = 0; ph < 16; ph++) begin
      write_reg(acps_pkg::REG_ZERO_LEVEL, $urandom_range(0, 4095));
      write_reg(acps_pkg::REG_MARGIN, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                                  : $urandom_range(0, 300));
      plen = (ph == 9) ? 2047 : $urandom_range(3, 20);
      write_reg(acps_pkg::REG_FRAME_LEN, plen);
      write_reg(acps_pkg::REG_GAIN, $urandom_range(0, 65535));
      if (plen > 1024) plen = 1024;
      if (ph == 15) tail_phase = 1;
      for (int f = 0; f < ((plen > 200) ? 1 : 3); f++) begin
        per = $urandom_range(2, 12);
        if ($urandom_range(0, 4) == 0) begin
          for (int i = 0; i < plen; i++)
            sample_queue.push_back(12'($urandom_range(0, 4095)));
        end else begin
          queue_wave_frame(plen, per);
        end
      end
      drain();
    end

    $display("Sent %0d samples and checked %0d frame results", samples_sent, frames_seen);
    $display("across frame lengths 3 to 1024, wrapped thresholds and extreme gains.");
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("ac_current_period_stats_core_test: clean");
    end else begin
      $display("ac_current_period_stats_core_test: errors");
    end
    $finish;
  end
endmodule
